// File: rtl/core/fpsc_pkg.sv
package fpsc_pkg;

	localparam int MAX_SIZE_LOG2 = 12;
	localparam int TRIG_TABLE_BITS = 10;
	localparam int N_W = 14;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [2:0] REG_PADDED_SIZE = 3'd0;
	localparam logic [2:0] REG_OUT_SIZE = 3'd1;
	localparam logic [2:0] REG_PHASE_STEP_X = 3'd2;
	localparam logic [2:0] REG_PHASE_STEP_Y = 3'd3;
	localparam logic [2:0] REG_RADIUS_SQR_LIMIT = 3'd4;
	localparam logic [2:0] REG_NORM_GAIN = 3'd5;

	typedef struct packed {
		logic [11:0] col_index;
		logic [11:0] row_index;
		logic signed [31:0] coef_real;
		logic signed [31:0] coef_imag;
	} item_t;

	typedef struct packed {
		logic [22:0] out_address;
		logic signed [31:0] out_real;
		logic signed [31:0] out_imag;
	} result_t;

	typedef struct packed {
		logic [N_W-1:0] n;
		logic [11:0] half;
		logic [11:0] o;
		logic [31:0] step_x;
		logic [31:0] step_y;
		logic [23:0] limit;
		logic [31:0] gain;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic pass;
		logic [22:0] addr;
		logic [31:0] phase;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} front_t;

	// Quarter-wave sine entry in Q0.15, Taylor series in Q2.30.
	function automatic logic [14:0] quarter_sine(input int unsigned i, input int unsigned tb);
		logic [63:0] x;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		x = (HALF_PI_Q30 * 64'(i) + (64'd1 << (tb - 1))) >> tb;
		term = x;
		sum = $signed(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				6: term = term / 64'd156;
				7: term = term / 64'd210;
				default: term = term / 64'd272;
			endcase
			if (n % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = 0;
		v = (sum + 64'sd16384) >>> 15;
		if (v > 64'sd32767) v = 64'sd32767;
		return v[14:0];
	endfunction

endpackage

// File: rtl/core/fpsc_front.sv
module fpsc_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input fpsc_pkg::item_t item,
	input fpsc_pkg::cfg_t cfg,
	output fpsc_pkg::front_t front
);

	localparam int W = fpsc_pkg::N_W;

	logic [W-1:0] row_w, col_w, half_w, o_w;
	logic keep;
	logic signed [W-1:0] kx, ky;
	logic [W-1:0] newrow;

	logic v_s1;
	logic signed [W-1:0] kx_s1, ky_s1;
	logic [12:0] newrow_s1;
	logic [11:0] col_s1;
	logic signed [31:0] re_s1, im_s1;

	logic v_s2;
	logic [2*W-1:0] kxsq_s2, kysq_s2;
	logic [31:0] px_s2, py_s2;
	logic [24:0] rowoff_s2;
	logic [11:0] col_s2;
	logic signed [31:0] re_s2, im_s2;

	logic v_s3, pass_s3;
	logic [22:0] addr_s3;
	logic [31:0] phase_s3;
	logic signed [31:0] re_s3, im_s3;

	logic [2*W:0] r2;
	logic [24:0] addr_full;

	assign row_w = W'(item.row_index);
	assign col_w = W'(item.col_index);
	assign half_w = W'(cfg.half);
	assign o_w = W'(cfg.o);
	assign keep = (row_w < cfg.n) && (col_w < o_w) &&
		((row_w < o_w) || (row_w >= cfg.n - o_w));
	assign kx = (col_w <= half_w) ? $signed(col_w) : $signed(col_w - cfg.n);
	assign ky = (row_w <= half_w) ? $signed(row_w) : $signed(row_w - cfg.n);
	assign newrow = (row_w < half_w) ? row_w + o_w : row_w + o_w - cfg.n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		kx_s1 <= kx;
		ky_s1 <= ky;
		newrow_s1 <= newrow[12:0];
		col_s1 <= item.col_index;
		re_s1 <= item.coef_real;
		im_s1 <= item.coef_imag;

		kxsq_s2 <= $unsigned((2*W)'(kx_s1) * (2*W)'(kx_s1));
		kysq_s2 <= $unsigned((2*W)'(ky_s1) * (2*W)'(ky_s1));
		px_s2 <= cfg.step_x * $unsigned(32'(kx_s1));
		py_s2 <= cfg.step_y * $unsigned(32'(ky_s1));
		rowoff_s2 <= 25'(newrow_s1) * 25'(cfg.o);
		col_s2 <= col_s1;
		re_s2 <= re_s1;
		im_s2 <= im_s1;

		pass_s3 <= r2 <= (2*W+1)'(cfg.limit);
		addr_s3 <= addr_full[22:0];
		phase_s3 <= 32'd0 - (px_s2 + py_s2);
		re_s3 <= re_s2;
		im_s3 <= im_s2;
	end

	assign r2 = (2*W+1)'(kxsq_s2) + (2*W+1)'(kysq_s2);
	assign addr_full = rowoff_s2 + 25'(col_s2);

	assign front.valid = v_s3;
	assign front.pass = pass_s3;
	assign front.addr = addr_s3;
	assign front.phase = phase_s3;
	assign front.re = re_s3;
	assign front.im = im_s3;

endmodule

// File: rtl/core/fpsc_trig.sv
module fpsc_trig #(
	parameter int TRIG_TABLE_BITS = fpsc_pkg::TRIG_TABLE_BITS
) (
	input logic clk,
	input logic [29:0] rest,
	output logic [14:0] sin_a,
	output logic [14:0] sin_b
);

	localparam int TB = TRIG_TABLE_BITS;
	localparam int M = 1 << TB;

	logic [14:0] rom [M+1];
	logic [30:0] rsum;
	logic [TB:0] j;
	logic [TB:0] jm;

	for (genvar g = 0; g <= M; g++) begin : g_rom
		assign rom[g] = fpsc_pkg::quarter_sine(g, TB);
	end

	assign rsum = {1'b0, rest} + (31'd1 << (29 - TB));
	assign j = rsum[30:30-TB];
	assign jm = (TB+1)'(M) - j;

	always_ff @(posedge clk) begin
		sin_a <= rom[j];
		sin_b <= rom[jm];
	end

endmodule

// File: rtl/core/fpsc_rot.sv
module fpsc_rot (
	input logic clk,
	input logic arst_n,
	input fpsc_pkg::front_t front,
	input logic [14:0] sin_a,
	input logic [14:0] sin_b,
	input logic [31:0] gain,
	output logic done,
	output fpsc_pkg::result_t result
);

	logic v_s4, pass_s4;
	logic [22:0] addr_s4;
	logic [1:0] quad_s4;
	logic signed [31:0] re_s4, im_s4;

	logic signed [16:0] sn, cs, a_x, b_x;

	logic v_s5, pass_s5;
	logic [22:0] addr_s5;
	logic signed [48:0] rc_s5, is_s5, rs_s5, ic_s5;

	logic signed [49:0] xr, xi, xr_sh, xi_sh;
	logic signed [31:0] nr, ni;

	logic v_s6, pass_s6;
	logic [22:0] addr_s6;
	logic signed [31:0] nr_s6, ni_s6;

	logic v_s7, pass_s7;
	logic [22:0] addr_s7;
	logic signed [65:0] gr_s7, gi_s7;
	logic signed [65:0] gr_sh, gi_sh;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) return 32'sh7fffffff;
		if (v < -50'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	assign a_x = $signed({2'b00, sin_a});
	assign b_x = $signed({2'b00, sin_b});

	always_comb begin
		case (quad_s4)
			2'd0: begin sn = a_x; cs = b_x; end
			2'd1: begin sn = b_x; cs = -a_x; end
			2'd2: begin sn = -a_x; cs = -b_x; end
			default: begin sn = -b_x; cs = a_x; end
		endcase
	end

	// round half up, then clamp
	assign xr = 50'(rc_s5) - 50'(is_s5);
	assign xi = 50'(rs_s5) + 50'(ic_s5);
	assign xr_sh = (xr + 50'sd16384) >>> 15;
	assign xi_sh = (xi + 50'sd16384) >>> 15;
	assign nr = sat32(xr_sh);
	assign ni = sat32(xi_sh);

	assign gr_sh = (gr_s7 + 66'sd2147483648) >>> 32;
	assign gi_sh = (gi_s7 + 66'sd2147483648) >>> 32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= front.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		pass_s4 <= front.pass;
		addr_s4 <= front.addr;
		quad_s4 <= front.phase[31:30];
		re_s4 <= front.re;
		im_s4 <= front.im;

		pass_s5 <= pass_s4;
		addr_s5 <= addr_s4;
		rc_s5 <= 49'(re_s4) * 49'(cs);
		is_s5 <= 49'(im_s4) * 49'(sn);
		rs_s5 <= 49'(re_s4) * 49'(sn);
		ic_s5 <= 49'(im_s4) * 49'(cs);

		pass_s6 <= pass_s5;
		addr_s6 <= addr_s5;
		nr_s6 <= nr;
		ni_s6 <= ni;

		pass_s7 <= pass_s6;
		addr_s7 <= addr_s6;
		gr_s7 <= 66'(nr_s6) * $signed({34'd0, gain});
		gi_s7 <= 66'(ni_s6) * $signed({34'd0, gain});

		result.out_address <= addr_s7;
		result.out_real <= pass_s7 ? gr_sh[31:0] : 32'sd0;
		result.out_imag <= pass_s7 ? gi_sh[31:0] : 32'sd0;
	end

endmodule

// File: rtl/core/fft_phase_shift_crop_mask.sv
// Channel   Ports                                    Transaction
// input     start, busy, item                        start high and busy low at clk
// result    done, result                             one cycle with done high
// config    cfg_we, cfg_index, cfg_data              cfg_we high at clk
//
// One coefficient enters per cycle; busy stays low. A result reaches the
// result ports through the eight-stage datapath (index and mask, squares
// and phase products, mask and phase, table read, rotation products,
// rounding, gain, output). Coefficients outside the crop are dropped at entry
// and give no result. Reset clears the valid bits and loads the register
// defaults. The result side has no back pressure, so nothing ever stalls.
module fft_phase_shift_crop_mask #(
	parameter int TRIG_TABLE_BITS = fpsc_pkg::TRIG_TABLE_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fpsc_pkg::item_t item,
	output logic done,
	output fpsc_pkg::result_t result,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int W = fpsc_pkg::N_W;
	localparam logic [W-1:0] MAX_N = W'(1) << fpsc_pkg::MAX_SIZE_LOG2;

	logic [12:0] padded_size_q;
	logic [11:0] out_size_q;
	logic [31:0] step_x_q, step_y_q, gain_q;
	logic [23:0] limit_q;

	logic [W-1:0] n_c;
	logic [11:0] half_c;
	fpsc_pkg::cfg_t cfg_c;
	fpsc_pkg::front_t front;
	logic [14:0] sin_a, sin_b;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			padded_size_q <= 13'd256;
			out_size_q <= 12'd128;
			step_x_q <= 32'd0;
			step_y_q <= 32'd0;
			limit_q <= 24'hffffff;
			gain_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				fpsc_pkg::REG_PADDED_SIZE: padded_size_q <= cfg_data[12:0];
				fpsc_pkg::REG_OUT_SIZE: out_size_q <= cfg_data[11:0];
				fpsc_pkg::REG_PHASE_STEP_X: step_x_q <= cfg_data;
				fpsc_pkg::REG_PHASE_STEP_Y: step_y_q <= cfg_data;
				fpsc_pkg::REG_RADIUS_SQR_LIMIT: limit_q <= cfg_data[23:0];
				fpsc_pkg::REG_NORM_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the size and crop once, ahead of the datapath
	assign n_c = (W'(padded_size_q) < W'(2)) ? W'(2) :
		(W'(padded_size_q) > MAX_N) ? MAX_N : W'(padded_size_q);
	assign half_c = n_c[12:1];

	always_comb begin
		cfg_c.n = n_c;
		cfg_c.half = half_c;
		cfg_c.o = (out_size_q > half_c) ? half_c : out_size_q;
		cfg_c.step_x = step_x_q;
		cfg_c.step_y = step_y_q;
		cfg_c.limit = limit_q;
		cfg_c.gain = gain_q;
	end

	fpsc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start && !busy),
		.item(item),
		.cfg(cfg_c),
		.front(front)
	);

	fpsc_trig #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_trig (
		.clk(clk),
		.rest(front.phase[29:0]),
		.sin_a(sin_a),
		.sin_b(sin_b)
	);

	fpsc_rot u_rot (
		.clk(clk),
		.arst_n(arst_n),
		.front(front),
		.sin_a(sin_a),
		.sin_b(sin_b),
		.gain(cfg_c.gain),
		.done(done),
		.result(result)
	);

endmodule
